### sv/lcp_pkg.sv
package lcp_pkg;

    localparam int COORD_W       = 16;
    localparam int DIFF_W        = COORD_W + 1;
    localparam int DOT_W         = 2 * DIFF_W + 2;
    localparam int PROD_W        = 2 * DOT_W;
    localparam int NUM_W         = PROD_W + 1;
    localparam int Q_W           = 32;
    localparam int DIV_LAT       = Q_W + 1;
    localparam int FRAC_BITS_DEF = 16;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_DEGEN = 2'd1;
    localparam logic [1:0] ST_SAT   = 2'd2;

    typedef struct packed {
        logic signed [COORD_W-1:0] first_start_x;
        logic signed [COORD_W-1:0] first_start_y;
        logic signed [COORD_W-1:0] first_start_z;
        logic signed [COORD_W-1:0] first_end_x;
        logic signed [COORD_W-1:0] first_end_y;
        logic signed [COORD_W-1:0] first_end_z;
        logic signed [COORD_W-1:0] second_start_x;
        logic signed [COORD_W-1:0] second_start_y;
        logic signed [COORD_W-1:0] second_start_z;
        logic signed [COORD_W-1:0] second_end_x;
        logic signed [COORD_W-1:0] second_end_y;
        logic signed [COORD_W-1:0] second_end_z;
    } lcp_in_t;

    typedef struct packed {
        logic [1:0]              status;
        logic signed [Q_W-1:0]   first_param;
        logic signed [Q_W-1:0]   second_param;
    } lcp_out_t;

    typedef struct packed {
        logic valid;
        logic degen;
    } lcp_side_t;

    typedef struct packed {
        logic signed [PROD_W-1:0] aa_bb;
        logic signed [PROD_W-1:0] ab_ab;
        logic signed [PROD_W-1:0] aw_bb;
        logic signed [PROD_W-1:0] ab_bw;
        logic signed [PROD_W-1:0] ab_aw;
        logic signed [PROD_W-1:0] aa_bw;
    } lcp_prod_t;

endpackage

### sv/lcp_front.sv
module lcp_front
    import lcp_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      en,
    input  logic      in_valid,
    input  lcp_in_t   in_data,
    output logic      out_valid,
    output lcp_prod_t out_prod
);

    function automatic logic signed [DOT_W-1:0] dot3(
        input logic signed [DIFF_W-1:0] a0, a1, a2, b0, b1, b2);
        dot3 = DOT_W'(a0) * DOT_W'(b0) + DOT_W'(a1) * DOT_W'(b1)
             + DOT_W'(a2) * DOT_W'(b2);
    endfunction

    logic                     v1_reg, v2_reg, v3_reg;
    logic signed [DIFF_W-1:0] d1_reg [3];
    logic signed [DIFF_W-1:0] d2_reg [3];
    logic signed [DIFF_W-1:0] w_reg  [3];
    logic signed [DOT_W-1:0]  aa_reg, bb_reg, ab_reg, aw_reg, bw_reg;
    lcp_prod_t                prod_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d1_reg[0] <= DIFF_W'(in_data.first_end_x) - DIFF_W'(in_data.first_start_x);
            d1_reg[1] <= DIFF_W'(in_data.first_end_y) - DIFF_W'(in_data.first_start_y);
            d1_reg[2] <= DIFF_W'(in_data.first_end_z) - DIFF_W'(in_data.first_start_z);
            d2_reg[0] <= DIFF_W'(in_data.second_end_x) - DIFF_W'(in_data.second_start_x);
            d2_reg[1] <= DIFF_W'(in_data.second_end_y) - DIFF_W'(in_data.second_start_y);
            d2_reg[2] <= DIFF_W'(in_data.second_end_z) - DIFF_W'(in_data.second_start_z);
            w_reg[0]  <= DIFF_W'(in_data.second_start_x) - DIFF_W'(in_data.first_start_x);
            w_reg[1]  <= DIFF_W'(in_data.second_start_y) - DIFF_W'(in_data.first_start_y);
            w_reg[2]  <= DIFF_W'(in_data.second_start_z) - DIFF_W'(in_data.first_start_z);

            aa_reg <= dot3(d1_reg[0], d1_reg[1], d1_reg[2], d1_reg[0], d1_reg[1], d1_reg[2]);
            bb_reg <= dot3(d2_reg[0], d2_reg[1], d2_reg[2], d2_reg[0], d2_reg[1], d2_reg[2]);
            ab_reg <= dot3(d1_reg[0], d1_reg[1], d1_reg[2], d2_reg[0], d2_reg[1], d2_reg[2]);
            aw_reg <= dot3(d1_reg[0], d1_reg[1], d1_reg[2], w_reg[0], w_reg[1], w_reg[2]);
            bw_reg <= dot3(d2_reg[0], d2_reg[1], d2_reg[2], w_reg[0], w_reg[1], w_reg[2]);

            prod_reg.aa_bb <= PROD_W'(aa_reg) * PROD_W'(bb_reg);
            prod_reg.ab_ab <= PROD_W'(ab_reg) * PROD_W'(ab_reg);
            prod_reg.aw_bb <= PROD_W'(aw_reg) * PROD_W'(bb_reg);
            prod_reg.ab_bw <= PROD_W'(ab_reg) * PROD_W'(bw_reg);
            prod_reg.ab_aw <= PROD_W'(ab_reg) * PROD_W'(aw_reg);
            prod_reg.aa_bw <= PROD_W'(aa_reg) * PROD_W'(bw_reg);
        end
    end

    assign out_valid = v3_reg;
    assign out_prod  = prod_reg;

endmodule

### sv/lcp_div.sv
module lcp_div
    import lcp_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic             aclk,
    input  logic             en,
    input  logic [NUM_W-1:0] mag,
    input  logic             neg,
    input  logic [NUM_W-1:0] den,
    output logic [Q_W-1:0]   quo,
    output logic             ovf,
    output logic             neg_out
);

    localparam int XW = NUM_W + FRAC_BITS;

    logic [XW-1:0]    x;
    logic [NUM_W-1:0] x_hi;

    logic [NUM_W-1:0] rem_reg [0:Q_W];
    logic [NUM_W-1:0] den_reg [0:Q_W];
    logic [Q_W-1:0]   lo_reg  [0:Q_W];
    logic [Q_W-1:0]   q_reg   [0:Q_W];
    logic             ovf_reg [0:Q_W];
    logic             neg_reg [0:Q_W];

    assign x    = {mag, FRAC_BITS'(0)};
    assign x_hi = NUM_W'(x[XW-1:Q_W]);

    // quotient fits Q_W bits only when the upper dividend part is below the divisor
    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0] <= x_hi;
            den_reg[0] <= den;
            lo_reg[0]  <= x[Q_W-1:0];
            q_reg[0]   <= '0;
            ovf_reg[0] <= (x_hi >= den);
            neg_reg[0] <= neg;
        end
    end

    for (genvar k = 1; k <= Q_W; k++) begin : g_step
        logic [NUM_W:0] trial;
        logic [NUM_W:0] diff;
        logic           ge;

        assign trial = {rem_reg[k-1], lo_reg[k-1][Q_W-1]};
        assign diff  = trial - {1'b0, den_reg[k-1]};
        assign ge    = (trial >= {1'b0, den_reg[k-1]});

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k] <= ge ? diff[NUM_W-1:0] : trial[NUM_W-1:0];
                den_reg[k] <= den_reg[k-1];
                lo_reg[k]  <= {lo_reg[k-1][Q_W-2:0], 1'b0};
                q_reg[k]   <= {q_reg[k-1][Q_W-2:0], ge};
                ovf_reg[k] <= ovf_reg[k-1];
                neg_reg[k] <= neg_reg[k-1];
            end
        end
    end

    assign quo     = q_reg[Q_W];
    assign ovf     = ovf_reg[Q_W];
    assign neg_out = neg_reg[Q_W];

endmodule

### sv/line_line_closest_params.sv
// Channel   Ports                       Payload
// input     s_valid s_ready s_data      lcp_in_t: two segments, 12 signed coordinates
// result    m_valid m_ready m_data      lcp_out_t: status, first_param, second_param
//
// One line pair enters per cycle while the output is not stalled. Three stages form
// differences, dot products and their products, one stage forms the determinant and
// numerators, 33 stages run two restoring dividers (a setup stage, then one quotient
// bit per stage), and a final register saturates and holds the result. Reset clears
// only the valid and degen bits. The whole pipeline holds while a result waits.
module line_line_closest_params
    import lcp_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  lcp_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output lcp_out_t m_data
);

    localparam logic [Q_W-1:0] POS_MAX = {1'b0, {(Q_W-1){1'b1}}};
    localparam logic [Q_W-1:0] NEG_MIN = {1'b1, {(Q_W-1){1'b0}}};

    logic      en;
    logic      front_valid;
    lcp_prod_t prod;

    logic signed [NUM_W-1:0] den_w, ns_w, nt_w;

    logic             v4_reg, degen4_reg;
    logic [NUM_W-1:0] den4_reg, mag_s_reg, mag_t_reg;
    logic             neg_s_reg, neg_t_reg;

    lcp_side_t side_reg [0:DIV_LAT-1];

    logic [Q_W-1:0] q_s, q_t;
    logic           ovf_s, ovf_t, neg_s, neg_t;
    logic [Q_W-1:0] par_s, par_t;
    logic           sat_s, sat_t;

    logic     m_valid_reg;
    lcp_out_t m_data_reg;
    lcp_out_t m_data_next;

    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    lcp_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_valid),
        .in_data   (s_data),
        .out_valid (front_valid),
        .out_prod  (prod)
    );

    assign den_w = NUM_W'(prod.aa_bb) - NUM_W'(prod.ab_ab);
    assign ns_w  = NUM_W'(prod.aw_bb) - NUM_W'(prod.ab_bw);
    assign nt_w  = NUM_W'(prod.ab_aw) - NUM_W'(prod.aa_bw);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
        end else if (en) begin
            v4_reg <= front_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            degen4_reg <= (den_w <= 0);
            den4_reg   <= den_w;
            neg_s_reg  <= ns_w[NUM_W-1];
            neg_t_reg  <= nt_w[NUM_W-1];
            mag_s_reg  <= ns_w[NUM_W-1] ? -ns_w : ns_w;
            mag_t_reg  <= nt_w[NUM_W-1] ? -nt_w : nt_w;
        end
    end

    lcp_div #(.FRAC_BITS(FRAC_BITS)) u_div_s (
        .aclk    (aclk),
        .en      (en),
        .mag     (mag_s_reg),
        .neg     (neg_s_reg),
        .den     (den4_reg),
        .quo     (q_s),
        .ovf     (ovf_s),
        .neg_out (neg_s)
    );

    lcp_div #(.FRAC_BITS(FRAC_BITS)) u_div_t (
        .aclk    (aclk),
        .en      (en),
        .mag     (mag_t_reg),
        .neg     (neg_t_reg),
        .den     (den4_reg),
        .quo     (q_t),
        .ovf     (ovf_t),
        .neg_out (neg_t)
    );

    // valid and degenerate flag ride alongside the divider stages
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < DIV_LAT; i++) begin
                side_reg[i] <= '0;
            end
        end else if (en) begin
            side_reg[0] <= '{valid: v4_reg, degen: degen4_reg};
            for (int i = 1; i < DIV_LAT; i++) begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    always_comb begin
        if (ovf_s) begin
            sat_s = 1'b1;
            par_s = neg_s ? NEG_MIN : POS_MAX;
        end else if (!neg_s) begin
            sat_s = (q_s > POS_MAX);
            par_s = sat_s ? POS_MAX : q_s;
        end else begin
            sat_s = (q_s > NEG_MIN);
            par_s = sat_s ? NEG_MIN : (Q_W'(0) - q_s);
        end
        if (ovf_t) begin
            sat_t = 1'b1;
            par_t = neg_t ? NEG_MIN : POS_MAX;
        end else if (!neg_t) begin
            sat_t = (q_t > POS_MAX);
            par_t = sat_t ? POS_MAX : q_t;
        end else begin
            sat_t = (q_t > NEG_MIN);
            par_t = sat_t ? NEG_MIN : (Q_W'(0) - q_t);
        end

        if (side_reg[DIV_LAT-1].degen) begin
            m_data_next.status       = ST_DEGEN;
            m_data_next.first_param  = '0;
            m_data_next.second_param = '0;
        end else begin
            m_data_next.status       = (sat_s || sat_t) ? ST_SAT : ST_OK;
            m_data_next.first_param  = par_s;
            m_data_next.second_param = par_t;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= side_reg[DIV_LAT-1].valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
